>>> rtl/depth_pixel_backprojection_defines.svh
// assertion macros shared by the checker
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// same-cycle implication under reset
`define DPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define DPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dpb_pkg.sv
`default_nettype none

package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;

    localparam int FOCAL_W  = 25;
    localparam int WORD_W   = 16;
    localparam int OUT_W    = 33;
    localparam int CFG_IDX_W = 3;

    localparam logic [FOCAL_W-1:0] INV_FOCAL_X_RST = 25'd31957;
    localparam logic [FOCAL_W-1:0] INV_FOCAL_Y_RST = 25'd31957;
    localparam logic [WORD_W-1:0]  CENTER_X_RST    = 16'd5112;
    localparam logic [WORD_W-1:0]  CENTER_Y_RST    = 16'd3832;
    localparam logic [WORD_W-1:0]  NO_SAMPLE_RST   = 16'd0;
    localparam logic [WORD_W-1:0]  SHADOW_RST      = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_FOCAL_X = 3'd0,
        CFG_INV_FOCAL_Y = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_NO_SAMPLE   = 3'd4,
        CFG_SHADOW      = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/dpb_ifs.sv
`default_nettype none

interface dpb_pix_if #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DEPTH_BITS-1:0] depth_mm;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [15:0]           ir_level;

    modport source (output valid, depth_mm, column, row, ir_level, input ready);
    modport sink   (input valid, depth_mm, column, row, ir_level, output ready);
endinterface

interface dpb_pt_if;
    import dpb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  x_q4;
    logic signed [OUT_W-1:0]  y_q4;
    logic [WORD_W-1:0]        z_out_mm;
    logic                     point_valid;
    logic [WORD_W-1:0]        intensity;

    modport source (output valid, x_q4, y_q4, z_out_mm, point_valid, intensity,
                    input ready);
    modport sink   (input valid, x_q4, y_q4, z_out_mm, point_valid, intensity,
                    output ready);
endinterface

interface dpb_cfg_if;
    import dpb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FOCAL_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/depth_pixel_backprojection.sv
// Back-projects one depth pixel per clock to a 3-D point through a pinhole model:
// x and y are ((pixel*16 - center) * depth * inv_focal) >> 24, floor-rounded and
// saturated to 33 bits signed, z is the depth, and the intensity passes through.
// Zero depth and the no-sample and shadow codes give a point with point_valid low
// and zero coordinates. The block takes one item per cycle through an offset
// stage, one multiplier stage for offset*depth, one for the product times the
// reciprocal focal length, and the rounding/saturation output register.
// Back-pressure on the point channel stalls the pipe without loss; bubbles
// are squeezed out. Configuration writes take effect at once, and new focal
// reciprocals reach items already in the pipe; write only while the pipe is empty.
`default_nettype none

module depth_pixel_backprojection #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpb_pix_if.sink   i_pix,
    dpb_cfg_if.sink   i_cfg,
    dpb_pt_if.source  o_pt
);
    import dpb_pkg::*;

    localparam int PIX_W = COORD_BITS + 4;
    localparam int MAG_W = (PIX_W > WORD_W) ? PIX_W : WORD_W;
    localparam int OFF_W = MAG_W + 1;
    localparam int P1_W  = MAG_W + DEPTH_BITS;
    localparam int P2_W  = P1_W + FOCAL_W;
    localparam int SUM_W = P2_W + 1;
    localparam int Q_W   = SUM_W - 24;

    localparam logic [SUM_W-1:0]  ROUND_UP = SUM_W'(24'hFF_FFFF);
    localparam logic [Q_W-1:0]    POS_LIM  = Q_W'(64'h0_FFFF_FFFF);
    localparam logic [Q_W-1:0]    NEG_LIM  = Q_W'(64'h1_0000_0000);
    localparam logic [OUT_W-1:0]  OUT_MAX  = 33'h0_FFFF_FFFF;
    localparam logic [OUT_W-1:0]  OUT_MIN  = 33'h1_0000_0000;

    // configuration registers
    logic [FOCAL_W-1:0] r_inv_fx, r_inv_fy;
    logic [WORD_W-1:0]  r_cen_x, r_cen_y, r_no_sample, r_shadow;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx    <= INV_FOCAL_X_RST;
            r_inv_fy    <= INV_FOCAL_Y_RST;
            r_cen_x     <= CENTER_X_RST;
            r_cen_y     <= CENTER_Y_RST;
            r_no_sample <= NO_SAMPLE_RST;
            r_shadow    <= SHADOW_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_INV_FOCAL_X: r_inv_fx    <= i_cfg.data;
                CFG_INV_FOCAL_Y: r_inv_fy    <= i_cfg.data;
                CFG_CENTER_X:    r_cen_x     <= i_cfg.data[WORD_W-1:0];
                CFG_CENTER_Y:    r_cen_y     <= i_cfg.data[WORD_W-1:0];
                CFG_NO_SAMPLE:   r_no_sample <= i_cfg.data[WORD_W-1:0];
                CFG_SHADOW:      r_shadow    <= i_cfg.data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables, bubbles collapse
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic en_a, en_b, en_c, en_d;

    assign en_d = !r_d_vld || o_pt.ready;
    assign en_c = !r_c_vld || en_d;
    assign en_b = !r_b_vld || en_c;
    assign en_a = !r_a_vld || en_b;
    assign i_pix.ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (en_a) r_a_vld <= i_pix.valid;
            if (en_b) r_b_vld <= r_a_vld;
            if (en_c) r_c_vld <= r_b_vld;
            if (en_d) r_d_vld <= r_c_vld;
        end
    end

    // stage a: signed offsets from the principal point, magnitude and sign
    logic [WORD_W-1:0] depth_ext;
    logic [OFF_W-1:0]  off_x, off_y;
    logic [OFF_W-1:0]  abs_x, abs_y;
    logic              n_a_bad;

    assign depth_ext = WORD_W'(i_pix.depth_mm);
    assign off_x = OFF_W'({i_pix.column, 4'b0000}) - OFF_W'(r_cen_x);
    assign off_y = OFF_W'({i_pix.row, 4'b0000}) - OFF_W'(r_cen_y);
    assign abs_x = off_x[OFF_W-1] ? -off_x : off_x;
    assign abs_y = off_y[OFF_W-1] ? -off_y : off_y;
    assign n_a_bad = (depth_ext == '0) || (depth_ext == r_no_sample)
                     || (depth_ext == r_shadow);

    logic [MAG_W-1:0]      r_a_mag_x, r_a_mag_y;
    logic                  r_a_neg_x, r_a_neg_y, r_a_bad;
    logic [DEPTH_BITS-1:0] r_a_depth;
    logic [WORD_W-1:0]     r_a_ir;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_mag_x <= abs_x[MAG_W-1:0];
            r_a_mag_y <= abs_y[MAG_W-1:0];
            r_a_neg_x <= off_x[OFF_W-1];
            r_a_neg_y <= off_y[OFF_W-1];
            r_a_bad   <= n_a_bad;
            r_a_depth <= i_pix.depth_mm;
            r_a_ir    <= i_pix.ir_level;
        end
    end

    // stage b: offset times depth
    logic [P1_W-1:0]       r_b_p_x, r_b_p_y;
    logic                  r_b_neg_x, r_b_neg_y, r_b_bad;
    logic [DEPTH_BITS-1:0] r_b_depth;
    logic [WORD_W-1:0]     r_b_ir;

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_p_x   <= P1_W'(r_a_mag_x) * P1_W'(r_a_depth);
            r_b_p_y   <= P1_W'(r_a_mag_y) * P1_W'(r_a_depth);
            r_b_neg_x <= r_a_neg_x;
            r_b_neg_y <= r_a_neg_y;
            r_b_bad   <= r_a_bad;
            r_b_depth <= r_a_depth;
            r_b_ir    <= r_a_ir;
        end
    end

    // stage c: times reciprocal focal length
    logic [P2_W-1:0]       r_c_p_x, r_c_p_y;
    logic                  r_c_neg_x, r_c_neg_y, r_c_bad;
    logic [DEPTH_BITS-1:0] r_c_depth;
    logic [WORD_W-1:0]     r_c_ir;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_p_x   <= P2_W'(r_b_p_x) * P2_W'(r_inv_fx);
            r_c_p_y   <= P2_W'(r_b_p_y) * P2_W'(r_inv_fy);
            r_c_neg_x <= r_b_neg_x;
            r_c_neg_y <= r_b_neg_y;
            r_c_bad   <= r_b_bad;
            r_c_depth <= r_b_depth;
            r_c_ir    <= r_b_ir;
        end
    end

    // stage d: floor shift, saturation, invalid masking
    logic [SUM_W-1:0] sum_x, sum_y;
    logic [Q_W-1:0]   q_x, q_y;
    logic [OUT_W-1:0] n_x, n_y;

    always_comb begin
        sum_x = SUM_W'(r_c_p_x) + (r_c_neg_x ? ROUND_UP : '0);
        sum_y = SUM_W'(r_c_p_y) + (r_c_neg_y ? ROUND_UP : '0);
        q_x = sum_x[SUM_W-1:24];
        q_y = sum_y[SUM_W-1:24];
        if (r_c_neg_x) begin
            n_x = (q_x > NEG_LIM) ? OUT_MIN : -q_x[OUT_W-1:0];
        end else begin
            n_x = (q_x > POS_LIM) ? OUT_MAX : q_x[OUT_W-1:0];
        end
        if (r_c_neg_y) begin
            n_y = (q_y > NEG_LIM) ? OUT_MIN : -q_y[OUT_W-1:0];
        end else begin
            n_y = (q_y > POS_LIM) ? OUT_MAX : q_y[OUT_W-1:0];
        end
        if (r_c_bad) begin
            n_x = '0;
            n_y = '0;
        end
    end

    logic [OUT_W-1:0]  r_d_x, r_d_y;
    logic [WORD_W-1:0] r_d_z, r_d_ir;
    logic              r_d_pv;

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_x  <= n_x;
            r_d_y  <= n_y;
            r_d_z  <= r_c_bad ? '0 : WORD_W'(r_c_depth);
            r_d_pv <= !r_c_bad;
            r_d_ir <= r_c_ir;
        end
    end

    assign o_pt.valid       = r_d_vld;
    assign o_pt.x_q4        = r_d_x;
    assign o_pt.y_q4        = r_d_y;
    assign o_pt.z_out_mm    = r_d_z;
    assign o_pt.point_valid = r_d_pv;
    assign o_pt.intensity   = r_d_ir;

endmodule

`default_nettype wire

>>> rtl/dpb_checker.sv
`default_nettype none

`include "depth_pixel_backprojection_defines.svh"

module dpb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [32:0] i_x_q4,
    input wire logic [32:0] i_y_q4,
    input wire logic [15:0] i_z_mm,
    input wire logic        i_point_valid,
    input wire logic [15:0] i_intensity
);
    logic out_stall;
    assign out_stall = i_out_valid && !i_out_ready;

    // a stalled point item holds
    `DPB_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_x_q4) && $stable(i_y_q4) && $stable(i_z_mm) && $stable(i_point_valid) && $stable(i_intensity), "stalled point item changed")

    // invalid measurement carries zero coordinates
    `DPB_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, i_out_valid && !i_point_valid, i_x_q4 == 33'd0 && i_y_q4 == 33'd0 && i_z_mm == 16'd0, "invalid point with nonzero coordinates")

    // a valid point never has zero range
    `DPB_ASSERT_IMP(a_good_range, i_clk, i_rst_n, i_out_valid && i_point_valid, i_z_mm != 16'd0, "valid point with zero range")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_pt.valid),
    .i_out_ready   (o_pt.ready),
    .i_x_q4        (o_pt.x_q4),
    .i_y_q4        (o_pt.y_q4),
    .i_z_mm        (o_pt.z_out_mm),
    .i_point_valid (o_pt.point_valid),
    .i_intensity   (o_pt.intensity)
);

`default_nettype wire

>>> verif/depth_pixel_backprojection_test.sv
`default_nettype none

module depth_pixel_backprojection_test;
    import dpb_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEMS_PER_PHASE = 206;
    localparam int RANDOM_PHASES   = 8;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [FOCAL_W-1:0] INV_FOCAL_MAX = 25'h1FFFFFF;
    localparam logic [OUT_W-1:0]   COORD_POS_SAT = 33'h0FFFFFFFF;
    localparam logic [OUT_W-1:0]   COORD_NEG_SAT = 33'h100000000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [DEPTH_BITS_DEF-1:0] depth_mm;
        logic [COORD_BITS_DEF-1:0] column;
        logic [COORD_BITS_DEF-1:0] row;
        logic [15:0]               ir_level;
    } pixel_t;

    typedef struct {
        logic signed [OUT_W-1:0] x_q4;
        logic signed [OUT_W-1:0] y_q4;
        logic [WORD_W-1:0]       z_out_mm;
        logic                    point_valid;
        logic [WORD_W-1:0]       intensity;
    } point_t;

    typedef struct {
        logic [FOCAL_W-1:0] inv_fx;
        logic [FOCAL_W-1:0] inv_fy;
        logic [WORD_W-1:0]  cx;
        logic [WORD_W-1:0]  cy;
        logic [WORD_W-1:0]  no_sample;
        logic [WORD_W-1:0]  shadow;
    } intrinsics_t;

    class point_ledger;
        intrinsics_t regs;
        point_t      points_due[$];
        int          errors;
        int          checked;

        function new();
            regs.inv_fx    = INV_FOCAL_X_RST;
            regs.inv_fy    = INV_FOCAL_Y_RST;
            regs.cx        = CENTER_X_RST;
            regs.cy        = CENTER_Y_RST;
            regs.no_sample = NO_SAMPLE_RST;
            regs.shadow    = SHADOW_RST;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FOCAL_W-1:0] value);
            case (idx)
                CFG_INV_FOCAL_X: regs.inv_fx    = value;
                CFG_INV_FOCAL_Y: regs.inv_fy    = value;
                CFG_CENTER_X:    regs.cx        = value[WORD_W-1:0];
                CFG_CENTER_Y:    regs.cy        = value[WORD_W-1:0];
                CFG_NO_SAMPLE:   regs.no_sample = value[WORD_W-1:0];
                CFG_SHADOW:      regs.shadow    = value[WORD_W-1:0];
                default: ;
            endcase
        endfunction

        // (pix*16 - center) * depth * inv, floor shift by 24, clamp to 33 bits
        function logic signed [OUT_W-1:0] lateral_q4(logic [COORD_BITS_DEF-1:0] pix,
                                                     logic [WORD_W-1:0] center,
                                                     logic [DEPTH_BITS_DEF-1:0] depth,
                                                     logic [FOCAL_W-1:0] inv);
            longint          offset;
            longint unsigned mag;
            longint unsigned prod;
            longint unsigned quo;
            longint          neg_val;
            offset = longint'(pix) * 16 - longint'(center);
            mag = (offset < 0) ? longint'(-offset) : offset;
            prod = mag * longint'(depth) * longint'(inv);
            if (offset < 0) begin
                quo = (prod + 64'hFFFFFF) >> 24;
                if (quo > 64'd4294967296)
                    return COORD_NEG_SAT;
                neg_val = -longint'(quo);
                return neg_val[OUT_W-1:0];
            end
            quo = prod >> 24;
            if (quo > 64'd4294967295)
                return COORD_POS_SAT;
            return quo[OUT_W-1:0];
        endfunction

        function void note_pixel(pixel_t px);
            point_t pt;
            pt.intensity = px.ir_level;
            if (px.depth_mm == 0 || px.depth_mm == regs.no_sample ||
                px.depth_mm == regs.shadow) begin
                pt.x_q4        = '0;
                pt.y_q4        = '0;
                pt.z_out_mm    = '0;
                pt.point_valid = 1'b0;
            end else begin
                pt.x_q4        = lateral_q4(px.column, regs.cx, px.depth_mm, regs.inv_fx);
                pt.y_q4        = lateral_q4(px.row, regs.cy, px.depth_mm, regs.inv_fy);
                pt.z_out_mm    = px.depth_mm;
                pt.point_valid = 1'b1;
            end
            points_due = {points_due, pt};
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (points_due.size() == 0) begin
                $error("point arrived with no pixel outstanding");
                errors++;
                return;
            end
            want = points_due.pop_front();
            checked++;
            if (got.x_q4 !== want.x_q4) begin
                $error("x_q4 expected %0d got %0d", want.x_q4, got.x_q4);
                errors++;
            end
            if (got.y_q4 !== want.y_q4) begin
                $error("y_q4 expected %0d got %0d", want.y_q4, got.y_q4);
                errors++;
            end
            if (got.z_out_mm !== want.z_out_mm) begin
                $error("z_out_mm expected %0d got %0d", want.z_out_mm, got.z_out_mm);
                errors++;
            end
            if (got.point_valid !== want.point_valid) begin
                $error("point_valid expected %0d got %0d", want.point_valid,
                       got.point_valid);
                errors++;
            end
            if (got.intensity !== want.intensity) begin
                $error("intensity expected %0d got %0d", want.intensity, got.intensity);
                errors++;
            end
        endfunction

        function int pending();
            return points_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dpb_pix_if pix_ch ();
    dpb_cfg_if cfg_ch ();
    dpb_pt_if  pt_ch ();

    depth_pixel_backprojection dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .i_cfg   (cfg_ch),
        .o_pt    (pt_ch)
    );

    point_ledger board = new();
    int send_gap_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_sent   = 0;
    int settings_used = 1;
    int cycle_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("depth_pixel_backprojection_test failed");
        $finish;
    end

    // point sink: check on handshake, then pick next ready
    initial begin
        point_t got;
        pt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pt_ch.valid && pt_ch.ready) begin
                got.x_q4        = pt_ch.x_q4;
                got.y_q4        = pt_ch.y_q4;
                got.z_out_mm    = pt_ch.z_out_mm;
                got.point_valid = pt_ch.point_valid;
                got.intensity   = pt_ch.intensity;
                board.check_point(got);
            end
            pt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic pixel_t mk_pixel(logic [15:0] depth, logic [11:0] col,
                                        logic [11:0] row, logic [15:0] ir);
        pixel_t px;
        px.depth_mm = depth;
        px.column   = col;
        px.row      = row;
        px.ir_level = ir;
        return px;
    endfunction

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 57; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 57; end
            default:       begin send_gap_pct = 6;  recv_stall_pct = 6;  end
        endcase
    endtask

    task automatic send_pixel(pixel_t px);
        while ($urandom_range(99) < send_gap_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.depth_mm <= px.depth_mm;
        pix_ch.column   <= px.column;
        pix_ch.row      <= px.row;
        pix_ch.ir_level <= px.ir_level;
        do @(posedge i_clk); while (!pix_ch.ready);
        board.note_pixel(px);
        pixels_sent++;
    endtask

    // drop valid and hold until every point is back
    task automatic drain_points();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic wait_idle();
        drain_points();
        repeat (PIPE_LATENCY * 2) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [FOCAL_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_reg(idx, value);
    endtask

    // upper data bits of the 16-bit registers carry junk that must be masked
    task automatic write_settings(intrinsics_t s);
        cfg_write(CFG_INV_FOCAL_X, s.inv_fx);
        cfg_write(CFG_INV_FOCAL_Y, s.inv_fy);
        cfg_write(CFG_CENTER_X,  {9'($urandom), s.cx});
        cfg_write(CFG_CENTER_Y,  {9'($urandom), s.cy});
        cfg_write(CFG_NO_SAMPLE, {9'($urandom), s.no_sample});
        cfg_write(CFG_SHADOW,    {9'($urandom), s.shadow});
        cfg_write(CFG_SPARE_A, FOCAL_W'($urandom));
        cfg_write(CFG_SPARE_B, FOCAL_W'($urandom));
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    function automatic logic [FOCAL_W-1:0] pick_inv_focal();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return FOCAL_W'($urandom_range(100000, 10000));
        if (r < 80)
            return FOCAL_W'($urandom_range(32'd16777216, 0));
        return FOCAL_W'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] pick_center();
        if ($urandom_range(1) == 0)
            return WORD_W'($urandom);
        return WORD_W'($urandom_range(4095) * 16 + $urandom_range(15));
    endfunction

    function automatic logic [WORD_W-1:0] pick_code();
        if ($urandom_range(3) == 0)
            return '0;
        return WORD_W'($urandom);
    endfunction

    function automatic logic [11:0] pick_coord(logic [WORD_W-1:0] center);
        int d;
        if ($urandom_range(9) < 7)
            return 12'($urandom);
        d = $urandom_range(4);
        return 12'((center >> 4) + d - 2);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        int r;
        r = $urandom_range(99);
        if (r < 8)       px.depth_mm = '0;
        else if (r < 16) px.depth_mm = board.regs.no_sample;
        else if (r < 24) px.depth_mm = board.regs.shadow;
        else if (r < 28) px.depth_mm = 16'hFFFF;
        else if (r < 34) px.depth_mm = 16'd1;
        else             px.depth_mm = 16'($urandom);
        px.column   = pick_coord(board.regs.cx);
        px.row      = pick_coord(board.regs.cy);
        px.ir_level = 16'($urandom);
        return px;
    endfunction

    initial begin
        intrinsics_t s;
        pix_ch.valid    <= 1'b0;
        pix_ch.depth_mm <= '0;
        pix_ch.column   <= '0;
        pix_ch.row      <= '0;
        pix_ch.ir_level <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset intrinsics, codes both zero
        set_idling(IDLE_NONE);
        send_pixel(mk_pixel(16'd0, 12'd320, 12'd240, 16'hFFFF));
        send_pixel(mk_pixel(16'd1, 12'd0, 12'd0, 16'h0000));
        send_pixel(mk_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF));
        send_pixel(mk_pixel(16'd1000, 12'd319, 12'd239, 16'h5A5A));
        send_pixel(mk_pixel(16'd1000, 12'd320, 12'd240, 16'hA5A5));
        send_pixel(mk_pixel(16'hFFFF, 12'd0, 12'hFFF, 16'h0001));
        send_pixel(mk_pixel(16'd2500, 12'hAAA, 12'h555, 16'h8000));
        send_pixel(mk_pixel(16'd7, 12'd1, 12'd1, 16'h7FFF));
        wait_idle();

        // top focal reciprocal, centers at both ends, distinct codes
        s.inv_fx    = INV_FOCAL_MAX;
        s.inv_fy    = INV_FOCAL_MAX;
        s.cx        = 16'h0000;
        s.cy        = 16'hFFFF;
        s.no_sample = 16'h1234;
        s.shadow    = 16'hFFFF;
        write_settings(s);
        send_pixel(mk_pixel(16'h1234, 12'd100, 12'd100, 16'h1111));
        send_pixel(mk_pixel(16'hFFFF, 12'd100, 12'd100, 16'h2222));
        send_pixel(mk_pixel(16'h0000, 12'd100, 12'd100, 16'h3333));
        // x clamps high and y clamps low, then both land just inside the limits
        send_pixel(mk_pixel(16'hFFFE, 12'hFFF, 12'd0, 16'h4444));
        send_pixel(mk_pixel(16'h8000, 12'hFFF, 12'd0, 16'h5555));
        // small products that round toward minus infinity
        send_pixel(mk_pixel(16'd1, 12'd0, 12'hFFF, 16'h6666));
        send_pixel(mk_pixel(16'd3, 12'd1, 12'hFFF, 16'h7777));
        send_pixel(mk_pixel(16'd2, 12'd0, 12'd0, 16'hFFFF));
        send_pixel(mk_pixel(16'h1235, 12'h800, 12'h800, 16'h0000));
        wait_idle();

        // same code for no-sample and shadow
        s.no_sample = 16'h0ABC;
        s.shadow    = 16'h0ABC;
        s.inv_fx    = 25'h1000000;
        s.inv_fy    = 25'd31957;
        s.cx        = 16'hFFFF;
        s.cy        = 16'h0000;
        write_settings(s);
        send_pixel(mk_pixel(16'h0ABC, 12'hFFF, 12'hFFF, 16'hBEEF));
        send_pixel(mk_pixel(16'h0ABD, 12'hFFF, 12'hFFF, 16'hCAFE));
        send_pixel(mk_pixel(16'hFFFF, 12'd0, 12'hFFF, 16'h0F0F));
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                s = '{default: '0};
            end else if (ph == 1) begin
                s.inv_fx    = INV_FOCAL_MAX;
                s.inv_fy    = INV_FOCAL_MAX;
                s.cx        = 16'hFFFF;
                s.cy        = 16'hFFFF;
                s.no_sample = 16'hFFFF;
                s.shadow    = 16'hFFFF;
            end else begin
                s.inv_fx    = pick_inv_focal();
                s.inv_fy    = pick_inv_focal();
                s.cx        = pick_center();
                s.cy        = pick_center();
                s.no_sample = pick_code();
                s.shadow    = pick_code();
            end
            write_settings(s);
            set_idling(idle_mode_t'(ph % 4));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain_points();
                send_pixel(random_pixel());
            end
            wait_idle();
        end

        $display("sent %0d pixels under %0d register settings, %0d points compared",
                 pixels_sent, settings_used, board.checked);
        $display("covered invalid codes, clamping, floor rounding and all idle mixes");
        if (board.errors == 0 && board.pending() == 0)
            $display("depth_pixel_backprojection_test passed");
        else
            $display("depth_pixel_backprojection_test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/dpb_pkg.sv
rtl/dpb_ifs.sv
rtl/depth_pixel_backprojection.sv
rtl/dpb_checker.sv
verif/depth_pixel_backprojection_test.sv
